@@ rtl/rmsn_pkg.sv @@
// Package: types and constants for the running mean/std normalizer.
package rmsn_pkg;

    localparam int unsigned SUM_W = 64;
    localparam int unsigned CNT_W = 32;
    localparam logic [63:0] VAR_MIN = 64'd429497;
    localparam logic [63:0] VAR_MAX = 64'd42949672960000;
    localparam logic [63:0] MEAN_LIMIT = 64'd1099511627776;
    localparam logic [31:0] ONE_Q16 = 32'd65536;
    localparam logic OP_ACC = 1'b0;
    localparam logic OP_NORM = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [3:0]  dim_index;
        logic signed [23:0] value;
        logic        last_of_observation;
    } rmsn_in_t;

    typedef struct packed {
        logic signed [23:0] normalized_value;
        logic        was_clipped;
    } rmsn_out_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_READ, ST_ACC, ST_DIV1, ST_DIV2, ST_MSQ, ST_VAR, ST_SQRT,
        ST_DIFF, ST_DIV3, ST_CLIP, ST_OUT
    } rmsn_state_t;

    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [63:0] den;
    } rmsn_div_req_t;

endpackage

@@ rtl/rmsn_ram.sv @@
// Generic single-port-write, registered-read RAM.
module rmsn_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ rtl/rmsn_div.sv @@
// Iterative 64/64 unsigned restoring divider, one quotient bit per cycle.
module rmsn_div (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  rmsn_pkg::rmsn_div_req_t req,
    output logic                   done,
    output logic [63:0]            quot
);
    logic [63:0] q_reg, q_next, r_reg, r_next, d_reg, d_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next, done_reg, done_next;
    logic [64:0] trial;

    always_comb begin
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = {r_reg, q_reg[63]} - {1'b0, d_reg};
        if (req.start) begin
            q_next = req.num;
            r_next = '0;
            d_next = req.den;
            cnt_next = 7'd64;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[64]) begin
                r_next = trial[63:0];
                q_next = {q_reg[62:0], 1'b1};
            end else begin
                r_next = {r_reg[62:0], q_reg[63]};
                q_next = {q_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done = done_reg;
    assign quot = q_reg;

    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg)) else $error("done without busy");
    a_cnt_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |-> cnt_reg == 7'd0) else $error("count while idle");
    a_no_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && cnt_reg > 7'd1 |=> busy_reg || req.start)
        else $error("divider stopped early");
endmodule

@@ rtl/rmsn_sqrt.sv @@
// Iterative 64-bit integer square root, one result bit per cycle.
module rmsn_sqrt (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        done,
    output logic [31:0] root
);
    logic [63:0] v_reg, v_next, res_reg, res_next, bit_reg, bit_next;
    logic        busy_reg, busy_next, done_reg, done_next;
    logic [63:0] rb;

    always_comb begin
        v_next = v_reg;
        res_next = res_reg;
        bit_next = bit_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rb = res_reg + bit_reg;
        if (start) begin
            v_next = radicand;
            res_next = '0;
            bit_next = 64'h4000_0000_0000_0000;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (v_reg >= rb) begin
                v_next = v_reg - rb;
                res_next = (res_reg >> 1) + bit_reg;
            end else begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg[0]) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        v_reg <= v_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign done = done_reg;
    assign root = res_reg[31:0];
endmodule

@@ rtl/running_mean_std_normalizer.sv @@
// Top level of the running mean/std normalizer.
// Accumulate items go through accept, memory read and write back. Normalize
// items use three passes of the shared serial divider (mean, mean of squares,
// scaled difference) and a square root, plus the memory read, the variance
// clamp and the difference step. While the count is zero or the dimension is
// out of range the square root is skipped. Sums live in two 64-bit RAMs; after
// reset a clearing pass over all DIMS entries runs before the first item is
// accepted. One item is in flight at a time; a finished result waits in the
// output register while further accumulate items proceed, and a following
// normalize item holds its result until the output register is free.
module running_mean_std_normalizer #(
    parameter int DIMS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  rmsn_pkg::rmsn_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output rmsn_pkg::rmsn_out_t m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [22:0]         cfg_data
);
    localparam int AW = (DIMS > 1) ? $clog2(DIMS) : 1;

    rmsn_pkg::rmsn_state_t state_reg, state_next;
    rmsn_pkg::rmsn_in_t    item_reg, item_next;
    logic [22:0] clip_reg;
    logic [31:0] cnt_reg, cnt_next;
    logic [AW:0] clr_reg;
    logic        clearing;
    logic        m_valid_reg, m_valid_next;
    rmsn_pkg::rmsn_out_t out_reg, out_next;
    rmsn_pkg::rmsn_out_t res_reg, res_next;
    logic [63:0] full_reg, full_next, msq_reg, msq_next, var_reg, var_next;
    logic [31:0] std_reg, std_next;
    logic        mneg_reg, mneg_next, dneg_reg, dneg_next, stats_reg, stats_next;

    logic        we;
    logic [AW-1:0] waddr, raddr;
    logic [63:0] sum_wd, sq_wd, sum_rd, sq_rd;
    rmsn_pkg::rmsn_div_req_t dreq;
    logic        ddone, sq_start, sq_done;
    logic [63:0] dquot;
    logic [31:0] sq_root;
    logic        in_range;
    logic signed [63:0] v64, sum_s, sum_add;
    logic [23:0] vmag;
    logic [47:0] sq_v;
    logic [63:0] sq_add, m2, var_c;
    logic [64:0] sq_tmp;
    logic signed [64:0] diff;
    logic signed [63:0] mean_s;

    assign clearing = !clr_reg[AW];
    assign in_range = (int'(item_reg.dim_index) < DIMS);

    rmsn_ram #(.WIDTH(64), .DEPTH(DIMS)) u_sum (.aclk(aclk), .we(we), .waddr(waddr),
        .wdata(sum_wd), .raddr(raddr), .rdata(sum_rd));
    rmsn_ram #(.WIDTH(64), .DEPTH(DIMS)) u_sq (.aclk(aclk), .we(we), .waddr(waddr),
        .wdata(sq_wd), .raddr(raddr), .rdata(sq_rd));
    rmsn_div u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .done(ddone), .quot(dquot));
    rmsn_sqrt u_sqrt (.aclk(aclk), .aresetn(aresetn), .start(sq_start),
        .radicand(var_reg), .done(sq_done), .root(sq_root));

    assign s_ready = (state_reg == rmsn_pkg::ST_IDLE) && !clearing;
    assign cfg_ready = 1'b1;
    assign m_valid = m_valid_reg;
    assign m_data = out_reg;
    assign raddr = AW'(item_reg.dim_index);

    always_comb begin
        state_next = state_reg;
        item_next = item_reg;
        cnt_next = cnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        out_next = out_reg;
        res_next = res_reg;
        full_next = full_reg;
        msq_next = msq_reg;
        var_next = var_reg;
        std_next = std_reg;
        mneg_next = mneg_reg;
        dneg_next = dneg_reg;
        stats_next = stats_reg;
        we = clearing;
        waddr = clearing ? clr_reg[AW-1:0] : raddr;
        sum_wd = '0;
        sq_wd = '0;
        dreq = '0;
        sq_start = 1'b0;
        v64 = 64'(item_reg.value);
        sum_s = sum_rd;
        sum_add = sum_s + v64;
        vmag = item_reg.value[23] ? 24'(-item_reg.value) : 24'(item_reg.value);
        sq_v = 48'(vmag) * 48'(vmag);
        sq_add = 64'(sq_v);
        sq_tmp = {1'b0, sq_rd} + {1'b0, sq_add};
        m2 = 64'(full_reg[31:0]) * 64'(full_reg[31:0]);
        var_c = (full_reg[63:32] != '0) ? '0 : (msq_reg >= m2 ? msq_reg - m2 : '0);
        mean_s = mneg_reg ? -$signed(full_reg > rmsn_pkg::MEAN_LIMIT ?
                 rmsn_pkg::MEAN_LIMIT : full_reg) :
                 $signed(full_reg > rmsn_pkg::MEAN_LIMIT ? rmsn_pkg::MEAN_LIMIT : full_reg);
        if (!stats_reg) mean_s = '0;
        diff = 65'(item_reg.value) - 65'(mean_s);
        case (state_reg)
            rmsn_pkg::ST_IDLE: begin
                if (s_valid && s_ready) begin
                    item_next = s_data;
                    state_next = rmsn_pkg::ST_READ;
                end
            end
            rmsn_pkg::ST_READ: begin
                state_next = (item_reg.operation == rmsn_pkg::OP_ACC) ?
                    rmsn_pkg::ST_ACC : rmsn_pkg::ST_DIV1;
            end
            rmsn_pkg::ST_ACC: begin
                if (in_range) begin
                    we = 1'b1;
                    if (v64 > 0 && sum_add < sum_s) sum_wd = 64'h7FFF_FFFF_FFFF_FFFF;
                    else if (v64 < 0 && sum_add > sum_s) sum_wd = 64'h8000_0000_0000_0000;
                    else sum_wd = sum_add;
                    sq_wd = sq_tmp[64] ? '1 : sq_tmp[63:0];
                end
                if (item_reg.last_of_observation && cnt_reg != '1) cnt_next = cnt_reg + 32'd1;
                state_next = rmsn_pkg::ST_IDLE;
            end
            rmsn_pkg::ST_DIV1: begin
                stats_next = in_range && cnt_reg != '0;
                mneg_next = sum_rd[63];
                msq_next = sq_rd;
                dreq.start = 1'b1;
                dreq.num = sum_rd[63] ? -sum_rd : sum_rd;
                dreq.den = {32'd0, cnt_reg};
                state_next = rmsn_pkg::ST_DIV2;
            end
            rmsn_pkg::ST_DIV2: begin
                if (ddone) begin
                    full_next = dquot;
                    dreq.start = 1'b1;
                    dreq.num = msq_reg;
                    dreq.den = {32'd0, cnt_reg};
                    state_next = rmsn_pkg::ST_MSQ;
                end
            end
            rmsn_pkg::ST_MSQ: begin
                if (ddone) begin
                    msq_next = dquot;
                    state_next = rmsn_pkg::ST_VAR;
                end
            end
            rmsn_pkg::ST_VAR: begin
                if (var_c < rmsn_pkg::VAR_MIN) var_next = rmsn_pkg::VAR_MIN;
                else if (var_c > rmsn_pkg::VAR_MAX) var_next = rmsn_pkg::VAR_MAX;
                else var_next = var_c;
                state_next = rmsn_pkg::ST_SQRT;
            end
            rmsn_pkg::ST_SQRT: begin
                if (!stats_reg) begin
                    std_next = rmsn_pkg::ONE_Q16;
                    state_next = rmsn_pkg::ST_DIFF;
                end else begin
                    sq_start = 1'b1;
                    state_next = rmsn_pkg::ST_CLIP;
                end
            end
            rmsn_pkg::ST_CLIP: begin
                if (sq_done) begin
                    std_next = sq_root;
                    state_next = rmsn_pkg::ST_DIFF;
                end
            end
            rmsn_pkg::ST_DIFF: begin
                dneg_next = diff[64];
                state_next = rmsn_pkg::ST_DIV3;
                dreq.start = 1'b1;
                dreq.num = (diff[64] ? 64'(-diff) : 64'(diff)) << 16;
                dreq.den = {32'd0, std_reg};
            end
            rmsn_pkg::ST_DIV3: begin
                if (ddone) begin
                    if (dquot > {41'd0, clip_reg}) begin
                        res_next.normalized_value = dneg_reg ? -24'(clip_reg) : 24'(clip_reg);
                        res_next.was_clipped = 1'b1;
                    end else begin
                        res_next.normalized_value = dneg_reg ? -dquot[23:0] : dquot[23:0];
                        res_next.was_clipped = 1'b0;
                    end
                    state_next = rmsn_pkg::ST_OUT;
                end
            end
            rmsn_pkg::ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    out_next = res_reg;
                    m_valid_next = 1'b1;
                    state_next = rmsn_pkg::ST_IDLE;
                end
            end
            default: state_next = rmsn_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rmsn_pkg::ST_IDLE;
            cnt_reg <= '0;
            clr_reg <= '0;
            m_valid_reg <= 1'b0;
            clip_reg <= 23'd327680;
        end else begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            m_valid_reg <= m_valid_next;
            if (clearing) clr_reg <= (clr_reg == (AW+1)'(DIMS - 1)) ?
                {1'b1, {AW{1'b0}}} : clr_reg + 1'b1;
            if (cfg_valid && cfg_ready) clip_reg <= cfg_data;
        end
        item_reg <= item_next;
        out_reg <= out_next;
        res_reg <= res_next;
        full_reg <= full_next;
        msq_reg <= msq_next;
        var_reg <= var_next;
        std_reg <= std_next;
        mneg_reg <= mneg_next;
        dneg_reg <= dneg_next;
        stats_reg <= stats_next;
    end

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == rmsn_pkg::ST_READ) else $error("accept lost");
    a_no_accept_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing |-> !s_ready) else $error("accept during clear");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data)) else $error("result dropped");
endmodule
